FILE: hw/rtl/unix_seconds_to_calendar_date_defines.svh
// Assertion macros shared by the calendar date converter.
`ifndef UNIX_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define UCD_CHECK(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define UCD_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ucd_pkg.sv
`default_nettype none

package ucd_pkg;

    // Where an input time falls relative to the representable calendar.
    typedef enum logic [1:0] {
        SPAN_OK   = 2'd0,
        SPAN_LOW  = 2'd1,
        SPAN_HIGH = 2'd2
    } span_t;

    // Earliest second that still maps to year 0, and first second of the
    // March-based year 65535, which no longer fits.
    localparam logic signed [62:0] SECS_MIN   = -63'sd62167219200;
    localparam logic signed [62:0] SECS_LIMIT = 63'sd2005922707200;

    // Seconds per day split as 128 * 675; the 675 part uses a reciprocal
    // estimate that is low by at most one.
    localparam logic [9:0]  DIV675     = 10'd675;
    localparam logic [24:0] RECIP_675  = 25'd25451658;   // floor(2^34 / 675)

    // Day count biased so that a 400-year era starts at zero, one era early.
    localparam logic [24:0] ZZ_OFFSET  = 25'd146037;
    localparam logic [17:0] ERA_DAYS   = 18'd146097;
    localparam logic [25:0] RECIP_ERA  = 26'd60207212;   // ceil(2^43 / 146097)

    // Exact reciprocals for the narrow divisions.
    localparam logic [17:0] RECIP_HOUR = 18'd149131;     // ceil(2^29 / 3600)
    localparam logic [12:0] RECIP_MIN  = 13'd4370;       // ceil(2^18 / 60)
    localparam logic [18:0] RECIP_1460 = 19'd367720;     // ceil(2^29 / 1460)
    localparam logic [18:0] RECIP_365  = 19'd367720;     // ceil(2^27 / 365)
    localparam logic [9:0]  RECIP_100  = 10'd656;        // ceil(2^16 / 100)
    localparam logic [11:0] RECIP_153  = 12'd3427;       // ceil(2^19 / 153)

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [17:0] CENTURY_DAYS  = 18'd36524;

    // Beat from the range check into the day split.
    typedef struct packed {
        logic [40:0] u;
        span_t       span;
    } split_t;

    // Beat carrying the biased day number and the second of the day.
    typedef struct packed {
        logic [24:0] dz;
        logic [16:0] sod;
        span_t       span;
    } day_t;

    // Beat carrying day of era, era year offset and the hour split.
    typedef struct packed {
        logic [17:0] doe;
        logic [15:0] y400;
        logic [4:0]  hour;
        logic [11:0] soh;
        logic [2:0]  wday;
        span_t       span;
    } era_t;

    // Beat carrying the March-based date and the full time of day.
    typedef struct packed {
        logic [15:0] ybase;
        logic [3:0]  mp;
        logic [8:0]  doy;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        span_t       span;
    } ymd_t;

    // Weekday of a biased day number: (dz + 6) mod 7 by folding octal digits.
    function automatic logic [2:0] wday_of(input logic [24:0] dz);
        logic [26:0] x;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [3:0]  r;
        x  = {2'b00, dz} + 27'd6;
        s1 = '0;
        for (int i = 0; i < 9; i++) begin
            s1 = s1 + {3'b000, x[3*i +: 3]};
        end
        s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
        if (s2 >= 4'd14) begin
            r = s2 - 4'd14;
        end else if (s2 >= 4'd7) begin
            r = s2 - 4'd7;
        end else begin
            r = s2;
        end
        return r[2:0];
    endfunction

    // Days from March 1 to the first day of the March-based month.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ucd_day_split.sv
`default_nettype none

// Floor division of the biased second count by 86400, in three stages.
module ucd_day_split (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ucd_pkg::split_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ucd_pkg::day_t       out_data
);
    import ucd_pkg::*;

    logic        a_vld_reg, b_vld_reg, c_vld_reg;
    logic        en_a, en_b, en_c;

    logic [41:0] a_plo_reg, a_phi_reg;
    logic [33:0] a_v_reg;
    logic [6:0]  a_low_reg;
    span_t       a_span_reg;

    logic [24:0] b_q_reg;
    logic [33:0] b_v_reg;
    logic [6:0]  b_low_reg;
    span_t       b_span_reg;

    day_t        c_out_reg;

    logic [33:0] v_next;
    logic [41:0] plo_next, phi_next;
    logic [58:0] prod_next;
    logic [34:0] qm_next;
    logic [33:0] rfull_next;
    logic [10:0] r_next;
    logic [10:0] r2_next;
    logic        rc_next;
    day_t        out_next;

    // Each stage loads when it is empty or when the stage after it moves.
    assign en_c     = !c_vld_reg || out_ready;
    assign en_b     = !b_vld_reg || en_c;
    assign en_a     = !a_vld_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (en_a) a_vld_reg <= in_valid;
            if (en_b) b_vld_reg <= a_vld_reg;
            if (en_c) c_vld_reg <= b_vld_reg;
        end
    end

    // Stage A: two partial products of (u / 128) by the reciprocal of 675.
    assign v_next   = in_data.u[40:7];
    assign plo_next = {25'd0, v_next[16:0]} * {17'd0, RECIP_675};
    assign phi_next = {25'd0, v_next[33:17]} * {17'd0, RECIP_675};

    // Stage B: combine the partial products into the quotient estimate.
    assign prod_next = {a_phi_reg[41:0], 17'd0} + {17'd0, a_plo_reg};

    // Stage C: remainder, and one correction step when the estimate was low.
    always_comb begin
        qm_next    = {10'd0, b_q_reg} * {25'd0, DIV675};
        rfull_next = b_v_reg - qm_next[33:0];
        r_next     = rfull_next[10:0];
        rc_next    = (r_next >= {1'b0, DIV675});
        r2_next    = rc_next ? (r_next - {1'b0, DIV675}) : r_next;
        out_next.dz   = rc_next ? (b_q_reg + 25'd1) : b_q_reg;
        out_next.sod  = {r2_next[9:0], b_low_reg};
        out_next.span = b_span_reg;
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_plo_reg  <= plo_next;
            a_phi_reg  <= phi_next;
            a_v_reg    <= v_next;
            a_low_reg  <= in_data.u[6:0];
            a_span_reg <= in_data.span;
        end
        if (en_b) begin
            b_q_reg    <= prod_next[58:34];
            b_v_reg    <= a_v_reg;
            b_low_reg  <= a_low_reg;
            b_span_reg <= a_span_reg;
        end
        if (en_c) begin
            c_out_reg  <= out_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_data  = c_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ucd_era.sv
`default_nettype none

// Splits the day number into era and day of era, and the second of the day
// into hour and second of the hour. Also derives the weekday.
module ucd_era (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ucd_pkg::day_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ucd_pkg::era_t      out_data
);
    import ucd_pkg::*;

    logic        a_vld_reg, b_vld_reg;
    logic        en_a, en_b;

    logic [7:0]  a_era_reg;
    logic [24:0] a_zz_reg;
    logic [4:0]  a_hour_reg;
    logic [16:0] a_sod_reg;
    logic [2:0]  a_wday_reg;
    span_t       a_span_reg;

    era_t        b_out_reg;

    logic [24:0] zz_next;
    logic [50:0] era_prod_next;
    logic [34:0] hour_prod_next;
    logic [25:0] em_next;
    logic [25:0] doe_full_next;
    logic [16:0] hm_next;
    logic [16:0] soh_full_next;
    logic [15:0] y400_next;
    era_t        out_next;

    assign en_b     = !b_vld_reg || out_ready;
    assign en_a     = !a_vld_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (en_a) a_vld_reg <= in_valid;
            if (en_b) b_vld_reg <= a_vld_reg;
        end
    end

    // Stage A: exact reciprocal quotients for the era and the hour.
    assign zz_next        = in_data.dz + ZZ_OFFSET;
    assign era_prod_next  = {26'd0, zz_next} * {25'd0, RECIP_ERA};
    assign hour_prod_next = {18'd0, in_data.sod} * {17'd0, RECIP_HOUR};

    // Stage B: remainders, and the era scaled to years less one era.
    always_comb begin
        em_next       = {18'd0, a_era_reg} * {8'd0, ERA_DAYS};
        doe_full_next = {1'b0, a_zz_reg} - em_next;
        hm_next       = {12'd0, a_hour_reg} * {5'd0, SECS_PER_HOUR};
        soh_full_next = a_sod_reg - hm_next;
        y400_next     = ({8'd0, a_era_reg} * 16'd400) - 16'd400;
        out_next.doe  = doe_full_next[17:0];
        out_next.y400 = y400_next;
        out_next.hour = a_hour_reg;
        out_next.soh  = soh_full_next[11:0];
        out_next.wday = a_wday_reg;
        out_next.span = a_span_reg;
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_era_reg  <= era_prod_next[50:43];
            a_zz_reg   <= zz_next;
            a_hour_reg <= hour_prod_next[33:29];
            a_sod_reg  <= in_data.sod;
            a_wday_reg <= wday_of(in_data.dz);
            a_span_reg <= in_data.span;
        end
        if (en_b) begin
            b_out_reg  <= out_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ucd_ymd.sv
`default_nettype none

// Turns the day of era into year of era, day of year and March-based month,
// and the second of the hour into minute and second, in four stages.
module ucd_ymd (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ucd_pkg::era_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ucd_pkg::ymd_t      out_data
);
    import ucd_pkg::*;

    logic        a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic        en_a, en_b, en_c, en_d;

    // Stage A registers.
    logic [6:0]  a_q1460_reg;
    logic [2:0]  a_qcent_reg;
    logic        a_last_reg;
    logic [17:0] a_doe_reg;
    logic [15:0] a_y400_reg;
    logic [4:0]  a_hour_reg;
    logic [5:0]  a_min_reg;
    logic [11:0] a_soh_reg;
    logic [2:0]  a_wday_reg;
    span_t       a_span_reg;

    // Stage B registers.
    logic [8:0]  b_yoe_reg;
    logic [17:0] b_doe_reg;
    logic [15:0] b_y400_reg;
    logic [4:0]  b_hour_reg;
    logic [5:0]  b_min_reg;
    logic [5:0]  b_sec_reg;
    logic [2:0]  b_wday_reg;
    span_t       b_span_reg;

    // Stage C registers.
    logic [8:0]  c_doy_reg;
    logic [15:0] c_ybase_reg;
    logic [4:0]  c_hour_reg;
    logic [5:0]  c_min_reg;
    logic [5:0]  c_sec_reg;
    logic [2:0]  c_wday_reg;
    span_t       c_span_reg;

    ymd_t        d_out_reg;

    logic [36:0] q1460_prod_next;
    logic [2:0]  qcent_next;
    logic [24:0] min_prod_next;
    logic [17:0] t_next;
    logic [36:0] yoe_prod_next;
    logic [11:0] sm_next;
    logic [11:0] sec_full_next;
    logic [18:0] yq_prod_next;
    logic [16:0] ydays_next;
    logic [17:0] doy_full_next;
    logic [10:0] x_next;
    logic [22:0] mp_prod_next;
    ymd_t        out_next;

    assign en_d     = !d_vld_reg || out_ready;
    assign en_c     = !c_vld_reg || en_d;
    assign en_b     = !b_vld_reg || en_c;
    assign en_a     = !a_vld_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            if (en_a) a_vld_reg <= in_valid;
            if (en_b) b_vld_reg <= a_vld_reg;
            if (en_c) c_vld_reg <= b_vld_reg;
            if (en_d) d_vld_reg <= c_vld_reg;
        end
    end

    // Stage A: leap corrections of the day of era, and the minute.
    always_comb begin
        q1460_prod_next = {19'd0, in_data.doe} * {18'd0, RECIP_1460};
        qcent_next = {2'd0, (in_data.doe >= CENTURY_DAYS)}
                   + {2'd0, (in_data.doe >= 18'd73048)}
                   + {2'd0, (in_data.doe >= 18'd109572)}
                   + {2'd0, (in_data.doe >= 18'd146096)};
        min_prod_next = {13'd0, in_data.soh} * {12'd0, RECIP_MIN};
    end

    // Stage B: year of era, and the second of the minute.
    always_comb begin
        t_next = a_doe_reg - {11'd0, a_q1460_reg} + {15'd0, a_qcent_reg}
               - {17'd0, a_last_reg};
        yoe_prod_next = {19'd0, t_next} * {18'd0, RECIP_365};
        sm_next       = {6'd0, a_min_reg} * {6'd0, SECS_PER_MIN};
        sec_full_next = a_soh_reg - sm_next;
    end

    // Stage C: day of the March-based year, and the year before the carry.
    always_comb begin
        yq_prod_next  = {10'd0, b_yoe_reg} * {9'd0, RECIP_100};
        ydays_next    = ({8'd0, b_yoe_reg} * 17'd365) + {10'd0, b_yoe_reg[8:2]}
                      - {15'd0, yq_prod_next[17:16]};
        doy_full_next = b_doe_reg - {1'b0, ydays_next};
    end

    // Stage D: March-based month from the day of year.
    always_comb begin
        x_next        = {c_doy_reg, 2'b00} + {2'b00, c_doy_reg} + 11'd2;
        mp_prod_next  = {12'd0, x_next} * {11'd0, RECIP_153};
        out_next.ybase  = c_ybase_reg;
        out_next.mp     = mp_prod_next[22:19];
        out_next.doy    = c_doy_reg;
        out_next.hour   = c_hour_reg;
        out_next.minute = c_min_reg;
        out_next.second = c_sec_reg;
        out_next.wday   = c_wday_reg;
        out_next.span   = c_span_reg;
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_q1460_reg <= q1460_prod_next[35:29];
            a_qcent_reg <= qcent_next;
            a_last_reg  <= (in_data.doe == 18'd146096);
            a_doe_reg   <= in_data.doe;
            a_y400_reg  <= in_data.y400;
            a_hour_reg  <= in_data.hour;
            a_min_reg   <= min_prod_next[23:18];
            a_soh_reg   <= in_data.soh;
            a_wday_reg  <= in_data.wday;
            a_span_reg  <= in_data.span;
        end
        if (en_b) begin
            b_yoe_reg   <= yoe_prod_next[35:27];
            b_doe_reg   <= a_doe_reg;
            b_y400_reg  <= a_y400_reg;
            b_hour_reg  <= a_hour_reg;
            b_min_reg   <= a_min_reg;
            b_sec_reg   <= sec_full_next[5:0];
            b_wday_reg  <= a_wday_reg;
            b_span_reg  <= a_span_reg;
        end
        if (en_c) begin
            c_doy_reg   <= doy_full_next[8:0];
            c_ybase_reg <= b_y400_reg + {7'd0, b_yoe_reg};
            c_hour_reg  <= b_hour_reg;
            c_min_reg   <= b_min_reg;
            c_sec_reg   <= b_sec_reg;
            c_wday_reg  <= b_wday_reg;
            c_span_reg  <= b_span_reg;
        end
        if (en_d) begin
            d_out_reg   <= out_next;
        end
    end

    assign out_valid = d_vld_reg;
    assign out_data  = d_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/unix_seconds_to_calendar_date.sv
`default_nettype none

`include "unix_seconds_to_calendar_date_defines.svh"

// Converts a signed count of seconds since 1970-01-01 00:00:00 into the
// proleptic Gregorian date and time: year, zero-based month and day, weekday
// (0 is Sunday), hour, minute and second. The block is an 11-stage pipeline
// that takes one timestamp per clock while the output is not stalled; stages
// hold their beats under back-pressure and empty stages keep filling, so no
// beat is lost or repeated. The stage count is set by the chain of reciprocal
// multiplies: the division by seconds per day, the era split, the year-of-era
// and month steps each get stages of their own. Times before 0000-01-01
// return year 0, January 1, weekday 6 with saturated set; times from
// March 1 of year 65535 on return the last second of year 65535 with weekday 6
// and saturated set.
module unix_seconds_to_calendar_date (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [62:0] s_seconds_since_epoch,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_year,
    output logic [3:0]              m_month,
    output logic [4:0]              m_day,
    output logic [2:0]              m_weekday,
    output logic [4:0]              m_hour,
    output logic [5:0]              m_minute,
    output logic [5:0]              m_second,
    output logic                    m_saturated
);
    import ucd_pkg::*;

    logic        in_vld_reg;
    split_t      in_data_reg;
    logic        en_in;
    logic        en_out;

    logic [62:0] diff_next;
    split_t      split_next;

    logic        ds_ready, ds_valid;
    day_t        ds_data;
    logic        er_ready, er_valid;
    era_t        er_data;
    logic        ym_ready, ym_valid;
    ymd_t        ym_data;

    logic        m_valid_reg;
    logic [15:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [2:0]  wday_reg, wday_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic        sat_reg, sat_next;

    logic [8:0]  dom_full;
    logic [3:0]  mon_calc;

    // Input stage: range check and bias so the second count is non-negative.
    assign en_in   = !in_vld_reg || ds_ready;
    assign s_ready = en_in;

    always_comb begin
        diff_next    = s_seconds_since_epoch - SECS_MIN;
        split_next.u = diff_next[40:0];
        if (s_seconds_since_epoch < SECS_MIN) begin
            split_next.span = SPAN_LOW;
        end else if (s_seconds_since_epoch >= SECS_LIMIT) begin
            split_next.span = SPAN_HIGH;
        end else begin
            split_next.span = SPAN_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en_in) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_in) begin
            in_data_reg <= split_next;
        end
    end

    ucd_day_split u_day_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_ready  (ds_ready),
        .in_data   (in_data_reg),
        .out_valid (ds_valid),
        .out_ready (er_ready),
        .out_data  (ds_data)
    );

    ucd_era u_era (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ds_valid),
        .in_ready  (er_ready),
        .in_data   (ds_data),
        .out_valid (er_valid),
        .out_ready (ym_ready),
        .out_data  (er_data)
    );

    ucd_ymd u_ymd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (er_valid),
        .in_ready  (ym_ready),
        .in_data   (er_data),
        .out_valid (ym_valid),
        .out_ready (en_out),
        .out_data  (ym_data)
    );

    // Output stage: day of month, January-based month, year carry and clamping.
    assign en_out = !m_valid_reg || m_ready;

    always_comb begin
        dom_full = ym_data.doy - month_start(ym_data.mp);
        mon_calc = (ym_data.mp < 4'd10) ? (ym_data.mp + 4'd2) : (ym_data.mp - 4'd10);
        case (ym_data.span)
            SPAN_LOW: begin
                year_next   = 16'd0;
                month_next  = 4'd0;
                day_next    = 5'd0;
                wday_next   = 3'd6;
                hour_next   = 5'd0;
                minute_next = 6'd0;
                second_next = 6'd0;
                sat_next    = 1'b1;
            end
            SPAN_HIGH: begin
                year_next   = 16'hFFFF;
                month_next  = 4'd11;
                day_next    = 5'd30;
                wday_next   = 3'd6;
                hour_next   = 5'd23;
                minute_next = 6'd59;
                second_next = 6'd59;
                sat_next    = 1'b1;
            end
            default: begin
                year_next   = ym_data.ybase + {15'd0, (mon_calc < 4'd2)};
                month_next  = mon_calc;
                day_next    = dom_full[4:0];
                wday_next   = ym_data.wday;
                hour_next   = ym_data.hour;
                minute_next = ym_data.minute;
                second_next = ym_data.second;
                sat_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= ym_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            wday_reg   <= wday_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_year      = year_reg;
    assign m_month     = month_reg;
    assign m_day       = day_reg;
    assign m_weekday   = wday_reg;
    assign m_hour      = hour_reg;
    assign m_minute    = minute_reg;
    assign m_second    = second_reg;
    assign m_saturated = sat_reg;

    // A full, stalled pipeline is the only reason to refuse input.
    `UCD_CHECK(a_stall_only_when_full, aclk, aresetn, !s_ready,
        m_valid && !m_ready, "input refused while the output is not stalled")

    // While fully stalled nothing drains, so input opens exactly with the output.
    `UCD_CHECK_NEXT(a_stall_holds, aclk, aresetn, !s_ready,
        s_ready == m_ready, "pipeline moved while fully stalled")

    // Unclamped results stay within calendar and clock ranges.
    `UCD_CHECK(a_fields_in_range, aclk, aresetn, m_valid && !m_saturated,
        m_month <= 4'd11 && m_day <= 5'd30 && m_weekday <= 3'd6 && m_hour <= 5'd23
        && m_minute <= 6'd59 && m_second <= 6'd59, "result field out of range")

    // February never has more than 29 days.
    `UCD_CHECK(a_february_length, aclk, aresetn,
        m_valid && !m_saturated && m_month == 4'd1, m_day <= 5'd28,
        "February day out of range")

    // Clamped results are one of the two fixed dates.
    `UCD_CHECK(a_clamp_dates, aclk, aresetn, m_valid && m_saturated,
        m_weekday == 3'd6 && ((m_year == 16'd0 && m_month == 4'd0)
        || (m_year == 16'hFFFF && m_month == 4'd11)), "bad clamped date")

endmodule

`default_nettype wire
